>>> rtl/uart_edge_timed_receiver_macros.svh
// assertion macros shared by the receiver rtl
`ifndef UART_EDGE_TIMED_RECEIVER_MACROS_SVH
`define UART_EDGE_TIMED_RECEIVER_MACROS_SVH

// same-cycle implication, disabled during reset
`define UETR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uart receiver check failed");

// next-cycle implication, disabled during reset
`define UETR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uart receiver sequence check failed");

`endif

>>> rtl/uetr_pkg.sv
// shared types, constants and helpers of the edge timed uart receiver
package uetr_pkg;

   localparam int TICKS_W  = 32;
   localparam int PERIOD_W = 24;
   localparam int WIN_W    = 14;
   localparam int CNT_W    = 4;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [CNT_W-1:0]    FRAME_BASE        = 4'd11;
   localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET  = 24'd104166;

   typedef enum logic [1:0] {
      REG_BIT_PERIOD    = 2'd0,
      REG_PARITY_ENABLE = 2'd1,
      REG_TWO_STOP_BITS = 2'd2,
      REG_INVERT_LINE   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic parity_enable;
      logic two_stop_bits;
   } fmt_type;

   typedef struct packed {
      logic shift;
      logic load_held;
      logic held_value;
   } win_ctrl_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] data;
   } win_status_type;

   // frame size: start, 8 data, optional parity, one or two stop bits, plus as many leading stop bits
   function automatic logic [CNT_W-1:0] frame_size(fmt_type fmt);
      frame_size = FRAME_BASE + {2'b00, fmt.two_stop_bits, 1'b0}
                   + {3'b000, fmt.parity_enable};
   endfunction

endpackage

>>> rtl/uetr_quot.sv
// shared subtract and compare unit that counts rounded bit periods
module uetr_quot (
   input  logic                           clock,
   input  logic                           load,
   input  logic                           step,
   input  logic [uetr_pkg::TICKS_W-1:0]   elapsed,
   input  logic [uetr_pkg::PERIOD_W-1:0]  period,
   output logic                           more
);

   localparam int REM_W = uetr_pkg::TICKS_W + 1;

   logic [REM_W-1:0]              rem_ff;
   logic [REM_W-1:0]              rem_in;
   logic [uetr_pkg::PERIOD_W-1:0] half;
   logic [REM_W-1:0]              period_ext;

   assign half       = {1'b0, period[uetr_pkg::PERIOD_W-1:1]};
   assign period_ext = REM_W'(period);
   assign more       = (rem_ff >= period_ext);

   always_comb begin
      rem_in = rem_ff;
      if (load) begin
         rem_in = {1'b0, elapsed} + REM_W'(half);
      end else if (step) begin
         rem_in = rem_ff - period_ext;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

endmodule

>>> rtl/uetr_window.sv
// frame window shifter with frame, parity and cut logic
module uetr_window (
   input  logic                     clock,
   input  logic                     reset,
   input  uetr_pkg::win_ctrl_type   ctrl,
   input  uetr_pkg::fmt_type        fmt,
   output uetr_pkg::win_status_type status
);

   localparam int WIN_W = uetr_pkg::WIN_W;
   localparam int CNT_W = uetr_pkg::CNT_W;

   logic [WIN_W-1:0] window_ff, window_in;
   logic             held_ff, held_in;
   logic [WIN_W-1:0] shifted, stop_m, sel_m, cut;
   logic [CNT_W-1:0] top_idx, par_idx, cut_amt;
   logic [7:0]       data;
   logic             frame_ok, par_ok;

   always_comb begin
      top_idx  = uetr_pkg::frame_size(fmt) - 4'd1;
      par_idx  = top_idx - 4'd1 - {3'b000, fmt.two_stop_bits};
      cut_amt  = top_idx - {3'b000, fmt.two_stop_bits};
      shifted  = {1'b0, window_ff[WIN_W-1:1]}
                 | (held_ff ? (WIN_W'(1) << top_idx) : '0);
      stop_m   = WIN_W'(1) | (WIN_W'(1) << top_idx);
      if (fmt.two_stop_bits) begin
         stop_m = stop_m | WIN_W'(2) | (WIN_W'(1) << (top_idx - 4'd1));
         sel_m  = stop_m | WIN_W'(4);
         data   = shifted[10:3];
      end else begin
         sel_m  = stop_m | WIN_W'(2);
         data   = shifted[9:2];
      end
      frame_ok = ((shifted & sel_m) == stop_m);
      par_ok   = !fmt.parity_enable || ((^data) == shifted[par_idx]);
      cut      = shifted >> cut_amt;
      status.hit  = frame_ok && par_ok;
      status.data = data;
   end

   always_comb begin
      window_in = window_ff;
      held_in   = held_ff;
      if (ctrl.shift) begin
         window_in = status.hit ? cut : shifted;
      end
      if (ctrl.load_held) begin
         held_in = ctrl.held_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         held_ff   <= 1'b1;
      end else begin
         window_ff <= window_in;
         held_ff   <= held_in;
      end
   end

endmodule

>>> rtl/uart_edge_timed_receiver.sv
// top level of the edge timed 8-bit uart receiver with register port and sequencer
// after an edge is taken the block runs one subtract-and-shift step per cycle, n steps in all,
//   n = rounded bit count capped at the frame size (11 to 14), then emits its bytes
// a new edge is taken only once the steps are done and every byte of the last edge is out;
//   the single subtractor in uetr_quot sets the step count, req_ready is low meanwhile
// reset: synchronous, registers return to defaults, window clears, held level goes high
`include "uart_edge_timed_receiver_macros.svh"

module uart_edge_timed_receiver (
   input  logic                           clock,
   input  logic                           reset,
   // edge event channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [uetr_pkg::TICKS_W-1:0]   req_elapsed_ticks,
   input  logic                           req_line_level,
   // received byte channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_data_byte,
   output logic                           rsp_last,
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [uetr_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [uetr_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [uetr_pkg::DATA_W-1:0]    csr_prdata,
   output logic                           csr_pready
);

   localparam int CNT_W    = uetr_pkg::CNT_W;
   localparam int PERIOD_W = uetr_pkg::PERIOD_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

   // ---------------- configuration registers ----------------
   logic [PERIOD_W-1:0]     bit_period_ff;
   logic                    parity_enable_ff;
   logic                    two_stop_bits_ff;
   logic                    invert_line_ff;
   logic                    csr_write;
   uetr_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = uetr_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff    <= uetr_pkg::BIT_PERIOD_RESET;
         parity_enable_ff <= 1'b0;
         two_stop_bits_ff <= 1'b0;
         invert_line_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            uetr_pkg::REG_BIT_PERIOD:    bit_period_ff    <= csr_pwdata[PERIOD_W-1:0];
            uetr_pkg::REG_PARITY_ENABLE: parity_enable_ff <= csr_pwdata[0];
            uetr_pkg::REG_TWO_STOP_BITS: two_stop_bits_ff <= csr_pwdata[0];
            uetr_pkg::REG_INVERT_LINE:   invert_line_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         uetr_pkg::REG_BIT_PERIOD:    csr_prdata = 32'(bit_period_ff);
         uetr_pkg::REG_PARITY_ENABLE: csr_prdata = 32'(parity_enable_ff);
         uetr_pkg::REG_TWO_STOP_BITS: csr_prdata = 32'(two_stop_bits_ff);
         uetr_pkg::REG_INVERT_LINE:   csr_prdata = 32'(invert_line_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // ---------------- datapath ----------------
   uetr_pkg::fmt_type        fmt;
   uetr_pkg::win_ctrl_type   win_ctrl;
   uetr_pkg::win_status_type win_status;
   logic [PERIOD_W-1:0]      period_eff;
   logic [CNT_W-1:0]         fsize;
   logic                     more;
   logic                     step;
   logic                     req_beat, rsp_beat;

   assign fmt.parity_enable = parity_enable_ff;
   assign fmt.two_stop_bits = two_stop_bits_ff;
   assign fsize             = uetr_pkg::frame_size(fmt);
   // a zero period behaves as one tick per bit
   assign period_eff = (bit_period_ff == '0) ? PERIOD_W'(1) : bit_period_ff;

   // ---------------- sequencer ----------------
   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;      // shifts done for this edge
   logic [1:0]       nbytes_ff;     // bytes collected for this edge
   logic             out_idx_ff;    // byte being offered
   logic             level_ff;      // new held level, applied after the shifts
   logic [7:0]       byte_ff [2];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_beat  = rsp_valid && rsp_ready;

   // one subtract and one shift per cycle until the remainder runs out or the frame is full
   assign step = (state_ff == ST_RUN) && more && (count_ff < fsize);

   assign win_ctrl.shift      = step;
   assign win_ctrl.load_held  = (state_ff == ST_RUN) && !step;
   assign win_ctrl.held_value = level_ff;

   assign rsp_data_byte = byte_ff[out_idx_ff];
   assign rsp_last      = out_idx_ff || (nbytes_ff == 2'd1);

   uetr_quot u_quot (
      .clock   (clock),
      .load    (req_beat),
      .step    (step),
      .elapsed (req_elapsed_ticks),
      .period  (period_eff),
      .more    (more)
   );

   uetr_window u_window (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (win_ctrl),
      .fmt    (fmt),
      .status (win_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         nbytes_ff  <= '0;
         out_idx_ff <= 1'b0;
         level_ff   <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  state_ff   <= ST_RUN;
                  count_ff   <= '0;
                  nbytes_ff  <= '0;
                  out_idx_ff <= 1'b0;
                  level_ff   <= req_line_level ^ invert_line_ff;
               end
            end
            ST_RUN: begin
               if (step) begin
                  count_ff <= count_ff + 4'd1;
                  // at most two frames fit in one edge, extras would be dropped
                  if (win_status.hit && (nbytes_ff != 2'd2)) begin
                     nbytes_ff <= nbytes_ff + 2'd1;
                  end
               end else if (nbytes_ff == 2'd0) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_beat) begin
                  if (rsp_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     out_idx_ff <= 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // byte store, no reset needed
   always_ff @(posedge clock) begin
      if (step && win_status.hit && (nbytes_ff != 2'd2)) begin
         byte_ff[nbytes_ff[0]] <= win_status.data;
      end
   end

   // ---------------- checks ----------------
   `UETR_ASSERT_NOW(a_emit_has_byte, clock, reset, rsp_valid,
      (nbytes_ff != 2'd0) && ({1'b0, out_idx_ff} < nbytes_ff))
   `UETR_ASSERT_NOW(a_count_capped, clock, reset, state_ff == ST_RUN, count_ff <= fsize)
   `UETR_ASSERT_NEXT(a_accept_runs, clock, reset, req_beat, state_ff == ST_RUN)
   `UETR_ASSERT_NEXT(a_last_frees, clock, reset, rsp_beat && rsp_last, req_ready)

endmodule
